### rtl/ar7seg_pkg.sv
// Shared definitions for the auto-ranging seven-segment scanner.
// Holds field widths, request codes and the digit glyph table; no dependencies.
package ar7seg_pkg;

    // Field widths.
    localparam int VALUE_W   = 17;
    localparam int DWELL_W   = 16;
    localparam int DIGITS    = 3;
    localparam int POS_W     = 2;
    localparam int SEG_W     = 8;
    localparam int SHOWN_W   = 10;

    // Loads at or above this many hundredths leave the display unchanged.
    localparam logic [VALUE_W-1:0] LOAD_LIMIT   = 17'd100000;
    localparam logic [VALUE_W-1:0] TENTHS_START = 17'd1000;
    localparam logic [VALUE_W-1:0] UNITS_START  = 17'd10000;

    localparam logic [SEG_W-1:0]   POINT_BIT    = 8'h80;
    localparam logic [DWELL_W-1:0] DWELL_RESET  = 16'd5;

    // Request codes.
    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    // Where the decimal point goes.
    typedef enum logic [1:0]
    {
        POINT_FIRST  = 2'd0,
        POINT_SECOND = 2'd1,
        POINT_NONE   = 2'd2
    } point_t;

    // Segment pattern for one decimal digit, segments a..g in bits 0..6.
    function automatic logic [SEG_W-1:0] glyph(input logic [3:0] digit);
        logic [SEG_W-1:0] pattern;
        begin
            case (digit)
                4'd0:    pattern = 8'h3F;
                4'd1:    pattern = 8'h06;
                4'd2:    pattern = 8'h5B;
                4'd3:    pattern = 8'h4F;
                4'd4:    pattern = 8'h66;
                4'd5:    pattern = 8'h6D;
                4'd6:    pattern = 8'h7D;
                4'd7:    pattern = 8'h07;
                4'd8:    pattern = 8'h7F;
                4'd9:    pattern = 8'h67;
                default: pattern = 8'h00;
            endcase
            return pattern;
        end
    endfunction

endpackage

### rtl/autorange_seven_segment_scanner.sv
// Top level of the auto-ranging three-digit seven-segment scanner.
// Depends on ar7seg_pkg for widths, request codes and the glyph table.
//
// The block takes one request per clock cycle while the output does not stall, and
// returns one result per request. A load request sets the three digit patterns from
// a value in hundredths, with the decimal point placed by range; a tick request
// advances the dwell counter and, after dwell_ticks ticks, moves the scan to the next
// digit. Each result is the digit select and segment pattern of the lit digit after
// the request takes effect. The range is chosen and the value is scaled by a
// reciprocal multiply in front of the input register; between the input register and
// the result register the digits are split out and the scan state is updated.
// A result passes through the input register and then the result register before it
// is offered; stalls on the output hold the input register in turn.
module autorange_seven_segment_scanner
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port.
    input  logic                                cfg_write_en,
    input  logic [ar7seg_pkg::DWELL_W-1:0]      cfg_write_data,
    // Request channel.
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                opcode,
    input  logic [ar7seg_pkg::VALUE_W-1:0]      value_hundredths,
    // Result channel.
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ar7seg_pkg::DIGITS-1:0]       digit_enable_n,
    output logic [ar7seg_pkg::SEG_W-1:0]        segments
);
    import ar7seg_pkg::*;

    // Configuration register.
    logic [DWELL_W-1:0] dwell_ticks_reg;

    // Input register stage.
    logic               s1_valid_reg;
    logic               s1_tick_reg;
    logic               s1_load_ok_reg;
    logic [SHOWN_W-1:0] s1_shown_reg;
    point_t             s1_point_reg;
    logic               s1_advance;

    // Display and scan state.
    logic [SEG_W-1:0]   pattern_reg [DIGITS];
    logic [SEG_W-1:0]   pattern_next [DIGITS];
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [DWELL_W-1:0] count_reg;
    logic [DWELL_W-1:0] count_next;

    // Result register.
    logic               out_valid_reg;
    logic [DIGITS-1:0]  enable_n_reg;
    logic [DIGITS-1:0]  enable_n_next;
    logic [SEG_W-1:0]   segments_reg;
    logic [SEG_W-1:0]   segments_next;

    // Range decode in front of the input register.
    logic [29:0]        tenths_prod;
    logic [31:0]        units_prod;
    logic [SHOWN_W-1:0] shown_in;
    point_t             point_in;

    // Digit split and tick arithmetic.
    logic [15:0]        hund_prod;
    logic [17:0]        ten_prod;
    logic [6:0]         tens_all;
    logic [14:0]        tens_prod;
    logic [3:0]         tens_hi;
    logic [3:0]         digit_val [DIGITS];
    logic [SHOWN_W-1:0] tens_times10;
    logic [6:0]         tens_hi_times10;
    logic [DWELL_W-1:0] limit;
    logic [DWELL_W:0]   count_inc;

    // Handshake: the input register moves on when the result register is free or being read.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign out_valid  = out_valid_reg;
    assign digit_enable_n = enable_n_reg;
    assign segments       = segments_reg;

    // Pick the range and scale the value: /10 is exact for 14-bit values via
    // 52429 / 2^19, and /100 is done as /4 followed by /25 via 5243 / 2^17.
    always_comb
    begin
        tenths_prod = 30'(value_hundredths[13:0]) * 30'd52429;
        units_prod  = 32'(value_hundredths[VALUE_W-1:2]) * 32'd5243;
        if (value_hundredths < TENTHS_START)
        begin
            shown_in = value_hundredths[SHOWN_W-1:0];
            point_in = POINT_FIRST;
        end
        else if (value_hundredths < UNITS_START)
        begin
            shown_in = tenths_prod[28:19];
            point_in = POINT_SECOND;
        end
        else
        begin
            shown_in = units_prod[26:17];
            point_in = POINT_NONE;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_tick_reg    <= (opcode == OP_TICK);
            s1_load_ok_reg <= (value_hundredths < LOAD_LIMIT);
            s1_shown_reg   <= shown_in;
            s1_point_reg   <= point_in;
        end
    end

    // Split the shown value into three decimal digits with small reciprocal multiplies.
    always_comb
    begin
        hund_prod       = 16'(s1_shown_reg) * 16'd41;
        ten_prod        = 18'(s1_shown_reg) * 18'd205;
        tens_all        = ten_prod[17:11];
        tens_prod       = 15'(tens_all) * 15'd205;
        tens_hi         = tens_prod[14:11];
        tens_times10    = SHOWN_W'(tens_all) * SHOWN_W'(10);
        tens_hi_times10 = 7'(tens_hi) * 7'd10;
        digit_val[0]    = hund_prod[15:12];
        digit_val[1]    = 4'(tens_all - tens_hi_times10);
        digit_val[2]    = 4'(s1_shown_reg - tens_times10);
    end

    // Next display and scan state.
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            pattern_next[i] = pattern_reg[i];
        end
        pos_next   = pos_reg;
        count_next = count_reg;
        limit      = (dwell_ticks_reg == '0) ? DWELL_W'(1) : dwell_ticks_reg;
        count_inc  = {1'b0, count_reg} + (DWELL_W+1)'(1);

        if (s1_tick_reg)
        begin
            if (count_inc >= {1'b0, limit})
            begin
                count_next = '0;
                pos_next   = (pos_reg >= POS_W'(DIGITS - 1)) ? '0 : pos_reg + POS_W'(1);
            end
            else
            begin
                count_next = count_inc[DWELL_W-1:0];
            end
        end
        else if (s1_load_ok_reg)
        begin
            for (int i = 0; i < DIGITS; i++)
            begin
                pattern_next[i] = glyph(digit_val[i]);
            end
            case (s1_point_reg)
                POINT_FIRST:  pattern_next[0] = pattern_next[0] | POINT_BIT;
                POINT_SECOND: pattern_next[1] = pattern_next[1] | POINT_BIT;
                default:      ;
            endcase
        end
    end

    // Drive the lit digit from the updated state.
    always_comb
    begin
        if (pos_next < POS_W'(DIGITS))
        begin
            enable_n_next = ~(DIGITS'(1) << pos_next);
            segments_next = pattern_next[pos_next];
        end
        else
        begin
            enable_n_next = '1;
            segments_next = '0;
        end
    end

    // State, configuration and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGITS; i++)
            begin
                pattern_reg[i] <= '0;
            end
            pos_reg         <= '0;
            count_reg       <= '0;
            dwell_ticks_reg <= DWELL_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                dwell_ticks_reg <= cfg_write_data;
            end
            if (s1_advance)
            begin
                for (int i = 0; i < DIGITS; i++)
                begin
                    pattern_reg[i] <= pattern_next[i];
                end
                pos_reg   <= pos_next;
                count_reg <= count_next;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            enable_n_reg <= enable_n_next;
            segments_reg <= segments_next;
        end
    end

endmodule

### tb/sv/autorange_seven_segment_scanner_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the auto-ranging seven-segment scanner.
// Depends on ar7seg_pkg and the autorange_seven_segment_scanner RTL; no files are read.
// A scoreboard class tracks the digit patterns and the scan, and checks every lit-digit result.
module autorange_seven_segment_scanner_tb;
    import ar7seg_pkg::*;

    localparam int RANDOM_PER_PHASE = 215;
    localparam int PHASES           = 8;
    localparam int STALL_LIMIT      = 2000;

    // One lit-digit result as seen on the output port.
    typedef struct packed
    {
        logic [DIGITS-1:0] digit_enable_n;
        logic [SEG_W-1:0]  segments;
    } lit_digit_t;

    // Tracks the display state and holds the lit digits still to come.
    class lit_digit_scoreboard;
        logic [SEG_W-1:0]   font [10];
        logic [SEG_W-1:0]   patterns [DIGITS];
        logic [POS_W-1:0]   position;
        logic [DWELL_W-1:0] dwell_count;
        logic [DWELL_W-1:0] dwell_ticks;
        lit_digit_t         lit_digit_q [$];
        int                 mismatches;

        function new();
            font = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h67};
            foreach (patterns[i])
                patterns[i] = '0;
            position    = '0;
            dwell_count = '0;
            dwell_ticks = DWELL_RESET;
            mismatches  = 0;
        endfunction

        // Picks the range, scales the value and places the decimal point.
        function void show_value(logic [VALUE_W-1:0] v);
            int unsigned shown;
            point_t      point;
            if (v >= LOAD_LIMIT)
                return;
            if (v < TENTHS_START)
            begin
                shown = v;
                point = POINT_FIRST;
            end
            else if (v < UNITS_START)
            begin
                shown = v / 10;
                point = POINT_SECOND;
            end
            else
            begin
                shown = v / 100;
                point = POINT_NONE;
            end
            patterns[0] = font[(shown / 100) % 10];
            patterns[1] = font[(shown / 10) % 10];
            patterns[2] = font[shown % 10];
            if (point != POINT_NONE)
                patterns[int'(point)] = patterns[int'(point)] | POINT_BIT;
        endfunction

        // A dwell of zero behaves like one; the scan wraps after the last digit.
        function void advance_scan();
            int unsigned limit;
            int unsigned next_count;
            limit      = (dwell_ticks == '0) ? 1 : int'(dwell_ticks);
            next_count = int'(dwell_count) + 1;
            if (next_count >= limit)
            begin
                dwell_count = '0;
                position    = (position >= POS_W'(DIGITS - 1)) ? '0 : position + 1'b1;
            end
            else
                dwell_count = next_count[DWELL_W-1:0];
        endfunction

        // Applies one accepted request and queues the lit digit it should produce.
        function void take_request(opcode_t op, logic [VALUE_W-1:0] v);
            lit_digit_t want;
            if (op == OP_LOAD)
                show_value(v);
            else
                advance_scan();
            if (position < POS_W'(DIGITS))
            begin
                want.digit_enable_n = ~(DIGITS'(1) << position);
                want.segments       = patterns[position];
            end
            else
            begin
                want.digit_enable_n = '1;
                want.segments       = '0;
            end
            lit_digit_q.push_back(want);
        endfunction

        // Compares one accepted result with the oldest queued lit digit.
        function void check_lit_digit(logic [DIGITS-1:0] sel, logic [SEG_W-1:0] seg);
            lit_digit_t want;
            if (lit_digit_q.size() == 0)
            begin
                $error("unexpected result: digit_enable_n=%b segments=%h", sel, seg);
                mismatches++;
                return;
            end
            want = lit_digit_q.pop_front();
            if (sel !== want.digit_enable_n)
            begin
                $error("digit_enable_n: expected %b, got %b", want.digit_enable_n, sel);
                mismatches++;
            end
            if (seg !== want.segments)
            begin
                $error("segments: expected %h, got %h", want.segments, seg);
                mismatches++;
            end
        endfunction

        function int pending();
            return lit_digit_q.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_write_en;
    logic [DWELL_W-1:0]  cfg_write_data;
    logic                in_valid;
    logic                in_ready;
    logic                opcode;
    logic [VALUE_W-1:0]  value_hundredths;
    logic                out_valid;
    logic                out_ready;
    logic [DIGITS-1:0]   digit_enable_n;
    logic [SEG_W-1:0]    segments;

    lit_digit_scoreboard sb;
    bit                  steady;

    autorange_seven_segment_scanner dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .value_hundredths (value_hundredths),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .digit_enable_n   (digit_enable_n),
        .segments         (segments)
    );

    // 100 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (steady || pick < 55)
            return 0;
        if (pick < 88)
            return $urandom_range(1, 3);
        if (pick < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Load values spread over every range, the range edges and the ignored values.
    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0, 1, 2: return VALUE_W'($urandom_range(0, 999));
            3, 4:    return VALUE_W'($urandom_range(1000, 9999));
            5, 6:    return VALUE_W'($urandom_range(10000, 99999));
            7:
            begin
                case ($urandom_range(0, 5))
                    0:       return VALUE_W'(999);
                    1:       return TENTHS_START;
                    2:       return VALUE_W'(9999);
                    3:       return UNITS_START;
                    4:       return VALUE_W'(99999);
                    default: return LOAD_LIMIT;
                endcase
            end
            8:       return VALUE_W'($urandom_range(100000, 131071));
            default: return VALUE_W'($urandom_range(0, 131071));
        endcase
    endfunction

    // Presents one request after a random gap and holds it until accepted.
    task automatic send_request(opcode_t op, logic [VALUE_W-1:0] v);
        int gap;
        gap = gap_len();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid         <= 1'b1;
        opcode           <= op;
        value_hundredths <= v;
        do
            @(posedge clk);
        while (!in_ready);
        sb.take_request(op, v);
    endtask

    // Mostly ticks, with loads mixed in.
    task automatic send_random();
        if ($urandom_range(0, 9) < 3)
            send_request(OP_LOAD, random_value());
        else
            send_request(OP_TICK, VALUE_W'($urandom_range(0, 131071)));
    endtask

    // Stops sending and waits until every queued lit digit has come back.
    task automatic drain_results(int settle);
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Writes the dwell register; the block must be idle.
    task automatic write_dwell(logic [DWELL_W-1:0] v);
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        sb.dwell_ticks = v;
    endtask

    // Result side: ready with random stalls.
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = gap_len();
            end
        end
    end

    // Checks each accepted result.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_lit_digit(digit_enable_n, segments);
    end

    // Ends the run if no request or result moves for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    // Stimulus: reset, directed requests, then random phases at several dwell settings.
    initial
    begin : stimulus
        logic [DWELL_W-1:0] dwell_plan [PHASES];
        sb               = new();
        steady           = 1'b0;
        rst_n            = 1'b0;
        cfg_write_en     = 1'b0;
        cfg_write_data   = '0;
        in_valid         = 1'b0;
        opcode           = OP_LOAD;
        value_hundredths = '0;
        // The largest dwell lets the count grow, so the next phase lowers it below the count.
        dwell_plan = '{16'd1, 16'd0, 16'd3, 16'd65535, 16'd2, 16'd4, 16'd5, 16'd5};
        dwell_plan[6] = DWELL_W'($urandom_range(6, 40));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Blank display first, then the range edges and the ignored loads.
        send_request(OP_TICK, '0);
        send_request(OP_LOAD, '0);
        send_request(OP_LOAD, VALUE_W'(999));
        send_request(OP_LOAD, TENTHS_START);
        send_request(OP_LOAD, VALUE_W'(9999));
        send_request(OP_LOAD, UNITS_START);
        send_request(OP_LOAD, VALUE_W'(99999));
        send_request(OP_LOAD, LOAD_LIMIT);
        send_request(OP_LOAD, '1);
        // Tick the scan on to the second digit; the ticks after the next load wrap it back.
        repeat (5) send_request(OP_TICK, '1);
        send_request(OP_LOAD, VALUE_W'(5));
        repeat (10) send_request(OP_TICK, '0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_results(4);
            steady = (phase == 2);
            write_dwell(dwell_plan[phase]);
            repeat (RANDOM_PER_PHASE)
            begin
                if ($urandom_range(0, 199) == 0)
                    drain_results(0);
                send_random();
            end
        end

        drain_results(8);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
